>>> rtl/tppfa_pkg.sv
// Shared types and constants of the two-pool page frame allocator.
package tppfa_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int PAGE_W    = 20;
  localparam int CNT_W     = 13;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // Stack capacity and stored frame width; the count fields above hold MAX_FRAMES.
  localparam int MAX_FRAMES = 4096;
  localparam int FRAME_BITS = PAGE_W;

  // Reset values of the configuration registers.
  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST  = '0;
  localparam logic [CNT_W-1:0]  KPOOL_SIZE_RST  = 13'd1024;
  localparam logic [CNT_W-1:0]  FRAME_COUNT_RST = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_RANGE = 3'd2,
    STAT_WRONG = 3'd3,
    STAT_FULL  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PAGE  = 2'd0,
    CFG_KPOOL_SIZE  = 2'd1,
    CFG_FRAME_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL
  } state_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic                granted;
    logic [PAGE_W-1:0]   frame_out;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    kernel_free;
    logic [CNT_W-1:0]    user_free;
    logic [CNT_W-1:0]    kernel_used;
    logic [CNT_W-1:0]    user_used;
  } out_word_t;

endpackage

>>> rtl/tppfa_in_if.sv
// Command channel interface of the page frame allocator.
interface tppfa_in_if
  import tppfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              pool;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output command, output pool, output page_number,
                  input ready);
  modport sink (input valid, input command, input pool, input page_number,
                output ready);
endinterface

>>> rtl/tppfa_out_if.sv
// Result channel interface of the page frame allocator.
interface tppfa_out_if
  import tppfa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                granted;
  logic [PAGE_W-1:0]   frame_out;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    kernel_free;
  logic [CNT_W-1:0]    user_free;
  logic [CNT_W-1:0]    kernel_used;
  logic [CNT_W-1:0]    user_used;

  modport source (output valid, output granted, output frame_out, output status,
                  output kernel_free, output user_free, output kernel_used,
                  output user_used, input ready);
  modport sink (input valid, input granted, input frame_out, input status,
                input kernel_free, input user_free, input kernel_used,
                input user_used, output ready);
endinterface

>>> rtl/tppfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tppfa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/two_pool_page_frame_allocator_top.sv
// Top level of the two-pool page frame allocator.
//
// Usage: commands arrive on in_ch (valid/ready), one word per command:
// allocate, free or initialize, with the pool and, for a free, the frame.
// Each command yields exactly one result word on out_ch (valid/ready)
// carrying grant, frame, status and both pools' free and used counts.
// Configuration registers (first page, kernel pool size, frame count) are
// written through cfg_we/cfg_index/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it. Both free stacks
// live in synchronous RAMs with a registered read. A free, an unknown command
// or an allocation from an empty pool is answered in the cycle after
// acceptance; a granted allocation first passes through S_READ for the stack
// RAM read. Initialize writes both stacks in parallel, one entry per cycle, up
// to the larger of the kernel and user shares, then loads its result. A new
// command is taken in S_IDLE once the output register is free or being read.
// Reset (rst_n low, synchronous) empties both stacks and zeroes the used
// counts; stack contents are only defined after an initialize. When the
// receiver stalls, the result stays in the output register and in_ch.ready
// stays low until the word is taken or is being taken in that cycle.
module two_pool_page_frame_allocator_top
  import tppfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tppfa_in_if.sink             in_ch,
  tppfa_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ADDR_W  = $clog2(MAX_FRAMES);
  localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);

  // Control state.
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;
  logic   in_ready;
  logic   acc;

  // Configuration registers.
  logic [PAGE_W-1:0] first_page_r;
  logic [CNT_W-1:0]  kpool_size_r;
  logic [CNT_W-1:0]  frame_count_r;

  // Stack depths and used counts.
  logic [DEPTH_W-1:0] kdepth_r, kdepth_nxt;
  logic [DEPTH_W-1:0] udepth_r, udepth_nxt;
  logic [DEPTH_W-1:0] kused_r, kused_nxt;
  logic [DEPTH_W-1:0] uused_r, uused_nxt;

  // Payload registers.
  out_word_t          out_r, out_nxt;
  logic [DEPTH_W-1:0] fill_r, fill_nxt;
  logic               rd_kern_r, rd_kern_nxt;

  // Derived values.
  logic [CNT_W-1:0]   mcount, kshare, ushare;
  logic [PAGE_W:0]    lo_ext, hi_ext, split_ext, page_ext;
  logic [DEPTH_W-1:0] sel_depth, sel_used, sel_dec, fill_end;
  logic [FRAME_BITS-1:0] first_fb;

  // Memory ports.
  logic                  k_we, u_we, k_re, u_re;
  logic [ADDR_W-1:0]     k_waddr, u_waddr, rd_addr;
  logic [FRAME_BITS-1:0] k_wdata, u_wdata, k_rdata, u_rdata, rd_frame;

  tppfa_ram #(.WIDTH(FRAME_BITS), .DEPTH(MAX_FRAMES)) u_kstack (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (rd_addr),
    .rdata (k_rdata)
  );

  tppfa_ram #(.WIDTH(FRAME_BITS), .DEPTH(MAX_FRAMES)) u_ustack (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (u_re),
    .raddr (rd_addr),
    .rdata (u_rdata)
  );

  // Pool sizes: managed count clamped to capacity, kernel share to that.
  assign mcount = (32'(frame_count_r) < MAX_FRAMES) ? frame_count_r : CNT_W'(MAX_FRAMES);
  assign kshare = (kpool_size_r < mcount) ? kpool_size_r : mcount;
  assign ushare = mcount - kshare;

  // Free bounds, one bit wider so that first page plus count cannot wrap.
  assign lo_ext    = {1'b0, first_page_r};
  assign hi_ext    = {1'b0, first_page_r} + (PAGE_W + 1)'(mcount);
  assign split_ext = {1'b0, first_page_r} + (PAGE_W + 1)'(kshare);
  assign page_ext  = {1'b0, in_ch.page_number};

  // Stack of the selected pool.
  assign sel_depth = in_ch.pool ? kdepth_r : udepth_r;
  assign sel_used  = in_ch.pool ? kused_r : uused_r;
  assign sel_dec   = sel_depth - DEPTH_W'(1);
  assign rd_addr   = sel_dec[ADDR_W-1:0];
  assign rd_frame  = rd_kern_r ? k_rdata : u_rdata;

  assign first_fb = FRAME_BITS'(first_page_r);
  assign fill_end = (kdepth_r > udepth_r) ? kdepth_r : udepth_r;

  // Handshake.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Command sequencer: next state, stack accesses and result word.
  always_comb begin
    state_nxt   = state_r;
    kdepth_nxt  = kdepth_r;
    udepth_nxt  = udepth_r;
    kused_nxt   = kused_r;
    uused_nxt   = uused_r;
    fill_nxt    = fill_r;
    rd_kern_nxt = rd_kern_r;
    out_nxt     = out_r;
    out_load    = 1'b0;
    k_we        = 1'b0;
    u_we        = 1'b0;
    k_re        = 1'b0;
    u_re        = 1'b0;
    k_waddr     = sel_depth[ADDR_W-1:0];
    u_waddr     = sel_depth[ADDR_W-1:0];
    k_wdata     = FRAME_BITS'(in_ch.page_number);
    u_wdata     = FRAME_BITS'(in_ch.page_number);

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_nxt.granted   = 1'b0;
          out_nxt.frame_out = '0;
          out_nxt.status    = STAT_OK;
          case (cmd_t'(in_ch.command))
            CMD_ALLOC: begin
              if (sel_depth == '0) begin
                out_nxt.status = STAT_EMPTY;
                out_load       = 1'b1;
              end else begin
                // Pop: read the top entry, answer once the data is back.
                k_re        = in_ch.pool;
                u_re        = !in_ch.pool;
                rd_kern_nxt = in_ch.pool;
                state_nxt   = S_READ;
                if (in_ch.pool) begin
                  kdepth_nxt = sel_dec;
                  if (kused_r < DEPTH_W'(MAX_FRAMES)) begin
                    kused_nxt = kused_r + DEPTH_W'(1);
                  end
                end else begin
                  udepth_nxt = sel_dec;
                  if (uused_r < DEPTH_W'(MAX_FRAMES)) begin
                    uused_nxt = uused_r + DEPTH_W'(1);
                  end
                end
              end
            end
            CMD_FREE: begin
              out_load = 1'b1;
              if (page_ext < lo_ext || page_ext >= hi_ext) begin
                out_nxt.status = STAT_RANGE;
              end else if (in_ch.pool && page_ext >= split_ext) begin
                out_nxt.status = STAT_WRONG;
              end else if (!in_ch.pool && page_ext < split_ext) begin
                out_nxt.status = STAT_WRONG;
              end else if (sel_depth == DEPTH_W'(MAX_FRAMES)) begin
                out_nxt.status = STAT_FULL;
              end else if (in_ch.pool) begin
                // Push onto the kernel stack.
                k_we       = 1'b1;
                kdepth_nxt = kdepth_r + DEPTH_W'(1);
                if (sel_used != '0) begin
                  kused_nxt = kused_r - DEPTH_W'(1);
                end
              end else begin
                // Push onto the user stack.
                u_we       = 1'b1;
                udepth_nxt = udepth_r + DEPTH_W'(1);
                if (sel_used != '0) begin
                  uused_nxt = uused_r - DEPTH_W'(1);
                end
              end
            end
            CMD_INIT: begin
              kdepth_nxt = DEPTH_W'(kshare);
              udepth_nxt = DEPTH_W'(ushare);
              kused_nxt  = '0;
              uused_nxt  = '0;
              if (mcount == '0) begin
                out_load = 1'b1;
              end else begin
                fill_nxt  = '0;
                state_nxt = S_FILL;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_nxt.granted   = 1'b1;
        out_nxt.frame_out = PAGE_W'(rd_frame);
        out_nxt.status    = STAT_OK;
        out_load          = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_FILL: begin
        // Both stacks fill in ascending frame order, one entry each per cycle until its share is written.
        k_we     = (fill_r < kdepth_r);
        u_we     = (fill_r < udepth_r);
        k_waddr  = fill_r[ADDR_W-1:0];
        u_waddr  = fill_r[ADDR_W-1:0];
        k_wdata  = first_fb + FRAME_BITS'(fill_r);
        u_wdata  = first_fb + FRAME_BITS'(kdepth_r) + FRAME_BITS'(fill_r);
        fill_nxt = fill_r + DEPTH_W'(1);
        if (fill_r == fill_end - DEPTH_W'(1)) begin
          out_nxt.granted   = 1'b0;
          out_nxt.frame_out = '0;
          out_nxt.status    = STAT_OK;
          out_load          = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Counts in the result are the values after the command.
    if (out_load) begin
      out_nxt.kernel_free = CNT_W'(kdepth_nxt);
      out_nxt.user_free   = CNT_W'(udepth_nxt);
      out_nxt.kernel_used = CNT_W'(kused_nxt);
      out_nxt.user_used   = CNT_W'(uused_nxt);
    end
  end

  // Output register valid flag.
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kdepth_r    <= '0;
      udepth_r    <= '0;
      kused_r     <= '0;
      uused_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kdepth_r    <= kdepth_nxt;
      udepth_r    <= udepth_nxt;
      kused_r     <= kused_nxt;
      uused_r     <= uused_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r  <= FIRST_PAGE_RST;
      kpool_size_r  <= KPOOL_SIZE_RST;
      frame_count_r <= FRAME_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_PAGE:  first_page_r  <= PAGE_W'(cfg_wdata);
        CFG_KPOOL_SIZE:  kpool_size_r  <= CNT_W'(cfg_wdata);
        CFG_FRAME_COUNT: frame_count_r <= CNT_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    fill_r    <= fill_nxt;
    rd_kern_r <= rd_kern_nxt;
  end

  // Result channel.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_r.granted;
  assign out_ch.frame_out   = out_r.frame_out;
  assign out_ch.status      = out_r.status;
  assign out_ch.kernel_free = out_r.kernel_free;
  assign out_ch.user_free   = out_r.user_free;
  assign out_ch.kernel_used = out_r.kernel_used;
  assign out_ch.user_used   = out_r.user_used;

  // A result is only loaded into a free or draining output register.
  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over an unread word");

  // A pop from a non-empty pool shows a grant after passing through S_READ.
  a_alloc_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.command == CMD_ALLOC && sel_depth != '0)
      |-> ##2 (out_valid_r && out_r.granted && out_r.status == STAT_OK))
    else $error("granted allocation not reported");

  // Stack depths stay within capacity.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (kdepth_r <= DEPTH_W'(MAX_FRAMES)) && (udepth_r <= DEPTH_W'(MAX_FRAMES)))
    else $error("stack depth beyond capacity");

  // No command is taken while a fill or a read is in progress.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("command accepted while busy");

endmodule
